// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the span coverage buffer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// A condition that must hold at every clock edge outside reset.
`define SCB_ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("scb invariant violated");
// A condition that must hold whenever the antecedent holds.
`define SCB_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scb implication violated");
`endif

// ===== rtl/scb_pkg.sv =====
// Shared constants and types of the span coverage buffer.
package scb_pkg;
    localparam int MaxRowsDef  = 256;
    localparam int MaxWidthDef = 512;
    localparam int MaxGapsDef  = 24;
    localparam int MaxResults  = 24;

    localparam int RowW       = 8;
    localparam int PixInW     = 9;
    localparam int LenW       = 10;
    localparam int WidthRegW  = 10;
    localparam int HeightRegW = 9;
    localparam int SpanCntW   = 16;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 16;
    localparam int ResCntW    = $clog2(MaxResults + 1);

    localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgScreenHeight = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgSpanCapacity = 2'd2;

    localparam logic [WidthRegW-1:0]  ScreenWidthRst  = 10'd320;
    localparam logic [HeightRegW-1:0] ScreenHeightRst = 9'd200;
    localparam logic [SpanCntW-1:0]   SpanCapacityRst = 16'hFFFF;

    localparam logic KindFrame = 1'b0;
    localparam logic KindEmit  = 1'b1;

    typedef struct packed {
        logic wr_bank0;
        logic wr_bank1;
        logic rd_bank;
    } gap_cmd_t;

    typedef struct packed {
        logic push;
        logic flush;
    } res_cmd_t;
endpackage

// ===== rtl/scb_gap_mem.sv =====
// Two banks of gap bounds, one written and the other read while a row is rebuilt.
module scb_gap_mem import scb_pkg::*; #(
    parameter int DEPTH  = MaxRowsDef * MaxGapsDef,
    parameter int ADDR_W = $clog2(MaxRowsDef * MaxGapsDef),
    parameter int DATA_W = 2 * $clog2(MaxWidthDef)
) (
    input  logic              clk,
    input  gap_cmd_t          cmd,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);
    logic [DATA_W-1:0] bank0_mem [DEPTH];
    logic [DATA_W-1:0] bank1_mem [DEPTH];
    logic [DATA_W-1:0] bank0_q_reg;
    logic [DATA_W-1:0] bank1_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_bank0)
        begin
            bank0_mem[wr_addr] <= wr_data;
        end
        bank0_q_reg <= bank0_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_bank1)
        begin
            bank1_mem[wr_addr] <= wr_data;
        end
        bank1_q_reg <= bank1_mem[rd_addr];
    end

    assign rd_data = cmd.rd_bank ? bank1_q_reg : bank0_q_reg;
endmodule

// ===== rtl/scb_count_mem.sv =====
// Per-row gap count and live bank, one read and one write a cycle.
module scb_count_mem import scb_pkg::*; #(
    parameter int ROWS   = MaxRowsDef,
    parameter int ADDR_W = $clog2(MaxRowsDef),
    parameter int DATA_W = $clog2(MaxGapsDef + 1) + 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);
    logic [DATA_W-1:0] count_mem [ROWS];
    logic [DATA_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            count_mem[wr_addr] <= wr_data;
        end
        q_reg <= count_mem[rd_addr];
    end

    assign rd_data = q_reg;
endmodule

// ===== rtl/scb_out_stage.sv =====
// Result holding stage: keeps one piece back so that the final one can be marked.
`include "assert_macros.svh"
module scb_out_stage import scb_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  res_cmd_t          rcmd,
    input  logic [RowW-1:0]   res_row,
    input  logic [PixInW-1:0] res_start,
    input  logic [LenW-1:0]   res_len,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [RowW-1:0]   out_row,
    output logic [PixInW-1:0] out_start,
    output logic [LenW-1:0]   out_length,
    output logic              last
);
    logic              pend_valid_reg, pend_valid_next;
    logic [RowW-1:0]   pend_row_reg;
    logic [PixInW-1:0] pend_start_reg;
    logic [LenW-1:0]   pend_len_reg;
    logic              out_valid_reg, out_valid_next;
    logic [RowW-1:0]   out_row_reg;
    logic [PixInW-1:0] out_start_reg;
    logic [LenW-1:0]   out_len_reg;
    logic              out_last_reg;
    logic              out_free;
    logic              load_out;

    assign out_free = !out_valid_reg || !out_stall;
    assign ready    = !pend_valid_reg || out_free;
    // The held item moves on whenever a newer one arrives or the item ends.
    assign load_out = pend_valid_reg && (rcmd.push || rcmd.flush);

    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        pend_valid_next = pend_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        if (rcmd.push)
        begin
            pend_valid_next = 1'b1;
        end
        else if (rcmd.flush)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rcmd.push)
        begin
            pend_row_reg   <= res_row;
            pend_start_reg <= res_start;
            pend_len_reg   <= res_len;
        end
        if (load_out)
        begin
            out_row_reg   <= pend_row_reg;
            out_start_reg <= pend_start_reg;
            out_len_reg   <= pend_len_reg;
            out_last_reg  <= rcmd.flush;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_start  = out_start_reg;
    assign out_length = out_len_reg;
    assign last       = out_last_reg;

    `SCB_ASSERT_IMPLIES(a_cmd_when_ready, clk, rst_n, rcmd.push || rcmd.flush, ready)
    `SCB_ASSERT_ALWAYS(a_push_flush_apart, clk, rst_n, !(rcmd.push && rcmd.flush))
endmodule

// ===== rtl/span_coverage_buffer.sv =====
// Span coverage buffer top level: row sequencer over the gap and count memories.
//
//   channel   direction  handshake            payload
//   in        to block   in_valid/in_stall    kind, row, span_left, span_right
//   out       from block out_valid/out_stall  out_row, out_start, out_length, last
//   cfg       to block   cfg_we               cfg_index, cfg_data
//
// After reset a clearing pass zeroes every row's gap count.
// A begin-frame item reinitialises every row below the screen height.
// An emit item streams the row's gap list through the single read port and
// rebuilds it in the other bank, and a split evaluates the same gap again.
// An emit whose row is outside the screen height or whose span is reversed is ignored.
// A stalled output holds the walk once both the output and the holding register are full.
`include "assert_macros.svh"
module span_coverage_buffer import scb_pkg::*; #(
    parameter int MAX_ROWS  = MaxRowsDef,
    parameter int MAX_WIDTH = MaxWidthDef,
    parameter int MAX_GAPS  = MaxGapsDef
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [RowW-1:0]       row,
    input  logic [PixInW-1:0]     span_left,
    input  logic [PixInW-1:0]     span_right,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [RowW-1:0]       out_row,
    output logic [PixInW-1:0]     out_start,
    output logic [LenW-1:0]       out_length,
    output logic                  last,
    input  logic                  cfg_we,
    input  logic [CfgIdxW-1:0]    cfg_index,
    input  logic [CfgDataW-1:0]   cfg_data
);
    localparam int RowAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PixW  = $clog2(MAX_WIDTH);
    localparam int CW    = ((PixW > PixInW) ? PixW : PixInW) + 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int ZW    = (WW > WidthRegW) ? WW : WidthRegW;
    localparam int HRW   = $clog2(MAX_ROWS + 1);
    localparam int HW    = (HRW > HeightRegW) ? HRW : HeightRegW;
    localparam int GIW   = $clog2(MAX_GAPS);
    localparam int GCW   = $clog2(MAX_GAPS + 1);
    localparam int AW    = $clog2(MAX_ROWS * MAX_GAPS);
    localparam int EW    = 2 * PixW;

    localparam logic [2:0] StClear   = 3'd0;
    localparam logic [2:0] StIdle    = 3'd1;
    localparam logic [2:0] StFrame   = 3'd2;
    localparam logic [2:0] StCntWait = 3'd3;
    localparam logic [2:0] StLoad    = 3'd4;
    localparam logic [2:0] StEval    = 3'd5;
    localparam logic [2:0] StDone    = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [RowAW-1:0]      sweep_reg, sweep_next;
    logic [WidthRegW-1:0]  sw_reg, sw_next;
    logic [HeightRegW-1:0] sh_reg, sh_next;
    logic [SpanCntW-1:0]   cap_reg, cap_next;
    logic [SpanCntW-1:0]   spans_reg, spans_next;
    logic                  bank_reg, bank_next;
    logic [GCW-1:0]        nold_reg, nold_next;
    logic [GCW-1:0]        cnt_reg, cnt_next;
    logic [GIW-1:0]        i_reg, i_next;
    logic [GIW-1:0]        j_reg, j_next;
    logic                  copy_reg, copy_next;
    logic [ResCntW-1:0]    nres_reg, nres_next;
    logic [RowAW-1:0]      row_reg, row_next;
    logic [RowW-1:0]       orow_reg, orow_next;
    logic [CW-1:0]         x1_reg, x1_next;
    logic [CW-1:0]         x2_reg, x2_next;
    logic [PixW-1:0]       wl_reg, wl_next;
    logic [PixW-1:0]       wr_reg, wr_next;

    logic [ZW-1:0]         eff_w;
    logic [PixW-1:0]       w_max;
    logic [HW-1:0]         eff_h;
    logic [GCW-1:0]        i_inc;
    logic [GCW-1:0]        i_look;
    logic [GIW-1:0]        rd_idx;

    gap_cmd_t              gcmd;
    logic [AW-1:0]         g_wr_addr;
    logic [EW-1:0]         g_wr_data;
    logic [AW-1:0]         g_rd_addr;
    logic [EW-1:0]         g_rd_data;

    logic                  c_we;
    logic [RowAW-1:0]      c_wr_addr;
    logic [GCW:0]          c_wr_data;
    logic [RowAW-1:0]      c_rd_addr;
    logic [GCW:0]          c_rd_data;

    res_cmd_t              rcmd;
    logic                  res_ready;
    logic [PixInW-1:0]     res_start;
    logic [LenW-1:0]       res_len;

    logic                  lt_left, gt_right, cut_left, in_right, full;
    logic                  do_wr, adv;

    function automatic logic [AW-1:0] gap_addr(input logic [RowAW-1:0] r,
                                               input logic [GIW-1:0] k);
        return AW'(r) * AW'(MAX_GAPS) + AW'(k);
    endfunction

    always_comb
    begin
        if (sw_reg == '0)
        begin
            eff_w = ZW'(1);
        end
        else if (ZW'(sw_reg) > ZW'(MAX_WIDTH))
        begin
            eff_w = ZW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = ZW'(sw_reg);
        end
        if (HW'(sh_reg) > HW'(MAX_ROWS))
        begin
            eff_h = HW'(MAX_ROWS);
        end
        else
        begin
            eff_h = HW'(sh_reg);
        end
    end

    assign w_max  = PixW'(eff_w - ZW'(1));
    assign i_inc  = GCW'(i_reg) + GCW'(1);
    // The read runs one gap ahead of the gap that the next cycle evaluates.
    assign i_look = GCW'(i_next) + GCW'(1);
    assign rd_idx = (state_reg == StCntWait) ? '0 :
                    ((i_look >= GCW'(MAX_GAPS)) ? GIW'(MAX_GAPS - 1) : GIW'(i_look));
    assign g_rd_addr = gap_addr(row_reg, rd_idx);

    assign lt_left  = CW'(wr_reg) < x1_reg;
    assign gt_right = CW'(wl_reg) > x2_reg;
    assign cut_left = CW'(wl_reg) < x1_reg;
    assign in_right = CW'(wr_reg) <= x2_reg;
    assign full     = cnt_reg >= GCW'(MAX_GAPS);

    assign res_start = PixInW'(wl_reg);
    assign res_len   = LenW'(CW'(wr_reg) - CW'(wl_reg) + CW'(1));

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        sw_next    = sw_reg;
        sh_next    = sh_reg;
        cap_next   = cap_reg;
        spans_next = spans_reg;
        bank_next  = bank_reg;
        nold_next  = nold_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        copy_next  = copy_reg;
        nres_next  = nres_reg;
        row_next   = row_reg;
        orow_next  = orow_reg;
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        wl_next    = wl_reg;
        wr_next    = wr_reg;

        gcmd         = '0;
        gcmd.rd_bank = bank_reg;
        g_wr_addr    = gap_addr(row_reg, j_reg);
        g_wr_data    = {wl_reg, wr_reg};
        c_we         = 1'b0;
        c_wr_addr    = sweep_reg;
        c_wr_data    = '0;
        c_rd_addr    = (state_reg == StIdle) ? RowAW'(row) : row_reg;
        rcmd         = '0;
        do_wr        = 1'b0;
        adv          = 1'b0;
        in_stall     = (state_reg != StIdle);

        if (cfg_we)
        begin
            case (cfg_index)
                CfgScreenWidth:  sw_next  = cfg_data[WidthRegW-1:0];
                CfgScreenHeight: sh_next  = cfg_data[HeightRegW-1:0];
                CfgSpanCapacity: cap_next = cfg_data[SpanCntW-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            StClear:
            begin
                c_we = 1'b1;
                if (sweep_reg == RowAW'(MAX_ROWS - 1))
                begin
                    sweep_next = '0;
                    state_next = StIdle;
                end
                else
                begin
                    sweep_next = sweep_reg + RowAW'(1);
                end
            end
            StIdle:
            begin
                if (in_valid)
                begin
                    if (kind == KindFrame)
                    begin
                        spans_next = '0;
                        sweep_next = '0;
                        if (eff_h != '0)
                        begin
                            state_next = StFrame;
                        end
                    end
                    else if ((HW'(row) < eff_h) && (span_right >= span_left))
                    begin
                        row_next   = RowAW'(row);
                        orow_next  = row;
                        x1_next    = CW'(span_left);
                        x2_next    = CW'(span_right);
                        state_next = StCntWait;
                    end
                end
            end
            StFrame:
            begin
                gcmd.wr_bank0 = 1'b1;
                gcmd.wr_bank1 = 1'b1;
                g_wr_addr     = gap_addr(sweep_reg, '0);
                g_wr_data     = {PixW'(0), w_max};
                c_we          = 1'b1;
                c_wr_data     = {1'b0, GCW'(1)};
                if (HW'(sweep_reg) == eff_h - HW'(1))
                begin
                    sweep_next = '0;
                    state_next = StIdle;
                end
                else
                begin
                    sweep_next = sweep_reg + RowAW'(1);
                end
            end
            StCntWait:
            begin
                bank_next = c_rd_data[GCW];
                nold_next = c_rd_data[GCW-1:0];
                cnt_next  = c_rd_data[GCW-1:0];
                i_next    = '0;
                j_next    = '0;
                copy_next = 1'b0;
                nres_next = '0;
                state_next = (c_rd_data[GCW-1:0] == '0) ? StDone : StLoad;
            end
            StLoad:
            begin
                wl_next    = g_rd_data[EW-1:PixW];
                wr_next    = g_rd_data[PixW-1:0];
                state_next = StEval;
            end
            StEval:
            begin
                if (copy_reg || lt_left)
                begin
                    do_wr = 1'b1;
                    adv   = 1'b1;
                end
                else if (gt_right)
                begin
                    do_wr     = 1'b1;
                    adv       = 1'b1;
                    copy_next = 1'b1;
                end
                else if (cut_left)
                begin
                    // A row that is already full abandons the rest of the item.
                    do_wr = 1'b1;
                    if (full)
                    begin
                        adv       = 1'b1;
                        copy_next = 1'b1;
                    end
                    else
                    begin
                        g_wr_data = {wl_reg, PixW'(x1_reg - CW'(1))};
                        cnt_next  = cnt_reg + GCW'(1);
                        wl_next   = PixW'(x1_reg);
                    end
                end
                else if (in_right)
                begin
                    if ((spans_reg < cap_reg) && (nres_reg < ResCntW'(MaxResults)))
                    begin
                        if (res_ready)
                        begin
                            rcmd.push  = 1'b1;
                            spans_next = spans_reg + SpanCntW'(1);
                            nres_next  = nres_reg + ResCntW'(1);
                            cnt_next   = cnt_reg - GCW'(1);
                            adv        = 1'b1;
                        end
                    end
                    else
                    begin
                        if (spans_reg < cap_reg)
                        begin
                            spans_next = spans_reg + SpanCntW'(1);
                        end
                        cnt_next = cnt_reg - GCW'(1);
                        adv      = 1'b1;
                    end
                end
                else
                begin
                    // The outer part goes out first; the inner part is then seen as visible.
                    do_wr = 1'b1;
                    if (full)
                    begin
                        adv       = 1'b1;
                        copy_next = 1'b1;
                    end
                    else
                    begin
                        g_wr_data = {PixW'(x2_reg + CW'(1)), wr_reg};
                        cnt_next  = cnt_reg + GCW'(1);
                        wr_next   = PixW'(x2_reg);
                    end
                end

                if (do_wr)
                begin
                    gcmd.wr_bank0 = bank_reg;
                    gcmd.wr_bank1 = !bank_reg;
                    j_next        = j_reg + GIW'(1);
                end
                if (adv)
                begin
                    if (i_inc == nold_reg)
                    begin
                        state_next = StDone;
                    end
                    else
                    begin
                        i_next  = i_reg + GIW'(1);
                        wl_next = g_rd_data[EW-1:PixW];
                        wr_next = g_rd_data[PixW-1:0];
                    end
                end
            end
            StDone:
            begin
                c_we      = 1'b1;
                c_wr_addr = row_reg;
                c_wr_data = {!bank_reg, cnt_reg};
                if (res_ready)
                begin
                    rcmd.flush = 1'b1;
                    state_next = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StClear;
            sweep_reg <= '0;
            sw_reg    <= ScreenWidthRst;
            sh_reg    <= ScreenHeightRst;
            cap_reg   <= SpanCapacityRst;
            spans_reg <= '0;
            bank_reg  <= 1'b0;
            nold_reg  <= '0;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            copy_reg  <= 1'b0;
            nres_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            sw_reg    <= sw_next;
            sh_reg    <= sh_next;
            cap_reg   <= cap_next;
            spans_reg <= spans_next;
            bank_reg  <= bank_next;
            nold_reg  <= nold_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            copy_reg  <= copy_next;
            nres_reg  <= nres_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        orow_reg <= orow_next;
        x1_reg   <= x1_next;
        x2_reg   <= x2_next;
        wl_reg   <= wl_next;
        wr_reg   <= wr_next;
    end

    scb_gap_mem #(
        .DEPTH  (MAX_ROWS * MAX_GAPS),
        .ADDR_W (AW),
        .DATA_W (EW)
    ) u_gap_mem (
        .clk     (clk),
        .cmd     (gcmd),
        .wr_addr (g_wr_addr),
        .wr_data (g_wr_data),
        .rd_addr (g_rd_addr),
        .rd_data (g_rd_data)
    );

    scb_count_mem #(
        .ROWS   (MAX_ROWS),
        .ADDR_W (RowAW),
        .DATA_W (GCW + 1)
    ) u_count_mem (
        .clk     (clk),
        .we      (c_we),
        .wr_addr (c_wr_addr),
        .wr_data (c_wr_data),
        .rd_addr (c_rd_addr),
        .rd_data (c_rd_data)
    );

    scb_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rcmd       (rcmd),
        .res_row    (orow_reg),
        .res_start  (res_start),
        .res_len    (res_len),
        .ready      (res_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_row    (out_row),
        .out_start  (out_start),
        .out_length (out_length),
        .last       (last)
    );

    `SCB_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= GCW'(MAX_GAPS))
    `SCB_ASSERT_IMPLIES(a_walk_in_list, clk, rst_n, state_reg == StEval, i_inc <= nold_reg)
    `SCB_ASSERT_ALWAYS(a_nres_bound, clk, rst_n, nres_reg <= ResCntW'(MaxResults))
endmodule
